### hdl/frq_pkg.sv
// Shared constants, types and codes of the frame reassembly queue.
package frq_pkg;

  // Ring depth; slot arithmetic wraps at a power of two.
  localparam int QDEPTH       = 16;
  localparam int AW           = $clog2(QDEPTH);
  localparam int OCW          = $clog2(QDEPTH + 1);
  localparam int MAX_FRAMES   = 8;
  localparam int FCW          = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int HEADER_BYTES = 4;
  localparam int TOTW         = 11;
  localparam logic [11:0] MAX_PKT_RESET = 12'd1024;

  typedef struct packed {
    logic [7:0] dest;
    logic [7:0] msg;
    logic [7:0] frames_left;
    logic [7:0] length;
  } hdr_t;

  typedef enum logic [1:0] {
    OP_FRAME = 2'd0,
    OP_RECV  = 2'd1,
    OP_FLOW  = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    ST_STORED     = 4'd0,
    ST_FULL       = 4'd1,
    ST_MALFORMED  = 4'd2,
    ST_SEGMENT    = 4'd3,
    ST_EMPTY      = 4'd4,
    ST_INCOMPLETE = 4'd5,
    ST_BAD_SEQ    = 4'd6,
    ST_TOO_MANY   = 4'd7,
    ST_FLOW       = 4'd8
  } status_t;

  typedef struct packed {
    status_t          status;
    logic [AW-1:0]    slot;
    logic [7:0]       seg_length;
    logic [7:0]       dest;
    logic [7:0]       msg;
    logic [TOTW-1:0]  total;
    logic             flow;
    logic             last;
  } result_t;

endpackage

### hdl/frame_reassembly_queue.sv
// Top level of the frame reassembly queue: sequencer, ring pointers and result register.
//
// The block keeps a ring of 16 frame headers and answers one transaction at a time: in_tready
// is high only while the sequencer is idle. Frame arrivals, flow queries and receive requests
// on an empty ring pass from the idle state to the decode state, which waits for a free result
// register and loads their result into it; a queue reset also passes through the decode state
// and gives no result. A receive request walks the header ring through the single read port
// of the header memory, one entry per cycle, and then reads the entries again to emit one
// segment result per cycle whenever the result register is free. One result register sits on
// the output side; the sequencer waits to load a result whenever it is full and not being
// drained. The max_packet_bytes register is written through cfg_wr_en and cfg_wr_data and
// resets to 1024.
module frame_reassembly_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // dest[7:0], msg[15:8], frames_left[23:16], payload_length[31:24],
  // received_length[40:32], zero fill [47:41]
  input  logic [47:0] in_tdata,
  // opcode[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // slot[3:0], seg_length[11:4], out_dest[19:12], out_msg[27:20],
  // pkt_total[38:28], flow[39]
  output logic [39:0] out_tdata,
  // status[3:0]
  output logic [3:0]  out_tuser,
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [11:0] cfg_wr_data
);

  localparam int AW   = frq_pkg::AW;
  localparam int OCW  = frq_pkg::OCW;
  localparam int FCW  = frq_pkg::FCW;
  localparam int TOTW = frq_pkg::TOTW;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_DECODE  = 6'b000010,
    S_CHECK   = 6'b000100,
    S_WALK    = 6'b001000,
    S_VERDICT = 6'b010000,
    S_EMIT    = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  frq_pkg::opcode_t  op_r, op_nxt;
  logic [40:0]       item_r, item_nxt;
  logic [AW-1:0]     wp_r, wp_nxt;
  logic [OCW-1:0]    occ_r, occ_nxt;
  logic              lack_r, lack_nxt;
  logic [11:0]       max_r;
  logic [7:0]        hd_r, hd_nxt;
  logic [7:0]        hm_r, hm_nxt;
  logic [FCW-1:0]    fr_r, fr_nxt;
  logic [FCW-1:0]    cnt_r, cnt_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [TOTW-1:0]   total_r, total_nxt;
  logic              bad_r, bad_nxt;
  logic              out_valid_r;
  frq_pkg::result_t  out_r;
  frq_pkg::result_t  res_nxt;
  logic              res_load;

  logic              mem_wr_en;
  logic              mem_rd_en;
  logic [AW-1:0]     mem_rd_addr;
  frq_pkg::hdr_t     mem_wr_data;
  frq_pkg::hdr_t     rd;

  logic              out_free;
  logic [AW-1:0]     head;
  logic [FCW-1:0]    fl_expect;
  logic [7:0]        in_plen;
  logic [8:0]        in_rlen;

  frq_hdr_mem u_hdr_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (wp_r),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (rd)
  );

  assign in_plen  = item_r[31:24];
  assign in_rlen  = item_r[40:32];
  assign mem_wr_data = '{dest: item_r[7:0], msg: item_r[15:8],
                         frames_left: item_r[23:16], length: item_r[31:24]};

  // A new result may be loaded when the register is empty or being drained.
  assign out_free  = !out_valid_r || out_tready;
  // Oldest committed slot; a full ring wraps back onto the write pointer.
  assign head      = wp_r - occ_r[AW-1:0];
  // During the walk cnt_r never exceeds fr_r, so this cannot wrap.
  assign fl_expect = fr_r - cnt_r;

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    item_nxt    = item_r;
    wp_nxt      = wp_r;
    occ_nxt     = occ_r;
    lack_nxt    = lack_r;
    hd_nxt      = hd_r;
    hm_nxt      = hm_r;
    fr_nxt      = fr_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    total_nxt   = total_r;
    bad_nxt     = bad_r;
    res_load    = 1'b0;
    res_nxt     = '0;
    mem_wr_en   = 1'b0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = frq_pkg::opcode_t'(in_tuser);
          item_nxt  = in_tdata[40:0];
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        unique case (op_r)
          frq_pkg::OP_FRAME: begin
            if (out_free) begin
              res_load     = 1'b1;
              res_nxt.last = 1'b1;
              state_nxt    = S_IDLE;
              if (occ_r == OCW'(frq_pkg::QDEPTH)) begin
                res_nxt.status = frq_pkg::ST_FULL;
              end else if ({1'b0, in_rlen} <
                           10'(frq_pkg::HEADER_BYTES) + {2'b00, in_plen}) begin
                res_nxt.status = frq_pkg::ST_MALFORMED;
              end else begin
                res_nxt.status = frq_pkg::ST_STORED;
                res_nxt.slot   = wp_r;
                mem_wr_en      = 1'b1;
                wp_nxt         = wp_r + AW'(1);
                occ_nxt        = occ_r + OCW'(1);
                lack_nxt       = 1'b0;
              end
            end
          end
          frq_pkg::OP_FLOW: begin
            if (out_free) begin
              res_load       = 1'b1;
              res_nxt.status = frq_pkg::ST_FLOW;
              res_nxt.flow   = (occ_r != '0) || lack_r;
              res_nxt.last   = 1'b1;
              state_nxt      = S_IDLE;
            end
          end
          frq_pkg::OP_CLEAR: begin
            wp_nxt    = '0;
            occ_nxt   = '0;
            lack_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end
          frq_pkg::OP_RECV: begin
            if (occ_r == '0) begin
              if (out_free) begin
                res_load       = 1'b1;
                res_nxt.status = frq_pkg::ST_EMPTY;
                res_nxt.last   = 1'b1;
                state_nxt      = S_IDLE;
              end
            end else begin
              mem_rd_en   = 1'b1;
              mem_rd_addr = head;
              idx_nxt     = head;
              state_nxt   = S_CHECK;
            end
          end
        endcase
      end

      // The head entry is on the read port.
      S_CHECK: begin
        if ({1'b0, rd.frames_left} >= 9'(occ_r)) begin
          if (out_free) begin
            res_load       = 1'b1;
            res_nxt.status = frq_pkg::ST_INCOMPLETE;
            res_nxt.last   = 1'b1;
            lack_nxt       = 1'b1;
            state_nxt      = S_IDLE;
          end
        end else if (rd.frames_left >= 8'(frq_pkg::MAX_FRAMES)) begin
          if (out_free) begin
            res_load       = 1'b1;
            res_nxt.status = frq_pkg::ST_TOO_MANY;
            res_nxt.last   = 1'b1;
            occ_nxt        = occ_r - OCW'(1);
            state_nxt      = S_IDLE;
          end
        end else begin
          // The head always matches itself, so it is counted right away.
          hd_nxt    = rd.dest;
          hm_nxt    = rd.msg;
          fr_nxt    = FCW'(rd.frames_left);
          total_nxt = TOTW'(rd.length);
          bad_nxt   = 1'b0;
          if (rd.frames_left == 8'd0) begin
            state_nxt = S_VERDICT;
          end else begin
            cnt_nxt     = FCW'(1);
            idx_nxt     = idx_r + AW'(1);
            mem_rd_en   = 1'b1;
            mem_rd_addr = idx_r + AW'(1);
            state_nxt   = S_WALK;
          end
        end
      end

      // Entry cnt_r of the run is on the read port.
      S_WALK: begin
        if (rd.dest != hd_r || rd.msg != hm_r || rd.frames_left != 8'(fl_expect)) begin
          bad_nxt   = 1'b1;
          state_nxt = S_VERDICT;
        end else begin
          total_nxt = total_r + TOTW'(rd.length);
          if (cnt_r == fr_r) begin
            state_nxt = S_VERDICT;
          end else begin
            cnt_nxt     = cnt_r + FCW'(1);
            idx_nxt     = idx_r + AW'(1);
            mem_rd_en   = 1'b1;
            mem_rd_addr = idx_r + AW'(1);
          end
        end
      end

      S_VERDICT: begin
        if (bad_r || {1'b0, total_r} > max_r) begin
          if (out_free) begin
            res_load       = 1'b1;
            res_nxt.status = frq_pkg::ST_BAD_SEQ;
            res_nxt.last   = 1'b1;
            occ_nxt        = occ_r - OCW'(1);
            state_nxt      = S_IDLE;
          end
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = head;
          idx_nxt     = head;
          cnt_nxt     = '0;
          state_nxt   = S_EMIT;
        end
      end

      // Segment cnt_r is on the read port; it is held until the result register frees.
      S_EMIT: begin
        if (out_free) begin
          res_load           = 1'b1;
          res_nxt.status     = frq_pkg::ST_SEGMENT;
          res_nxt.slot       = idx_r;
          res_nxt.seg_length = rd.length;
          res_nxt.dest       = hd_r;
          res_nxt.msg        = hm_r;
          res_nxt.total      = total_r;
          res_nxt.last       = (cnt_r == fr_r);
          if (cnt_r == fr_r) begin
            occ_nxt   = occ_r - (OCW'(fr_r) + OCW'(1));
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt     = cnt_r + FCW'(1);
            idx_nxt     = idx_r + AW'(1);
            mem_rd_en   = 1'b1;
            mem_rd_addr = idx_r + AW'(1);
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      occ_r       <= '0;
      lack_r      <= 1'b0;
      max_r       <= frq_pkg::MAX_PKT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      occ_r   <= occ_nxt;
      lack_r  <= lack_nxt;
      if (cfg_wr_en) begin
        max_r <= cfg_wr_data;
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers of the sequencer carry payload only.
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    item_r  <= item_nxt;
    hd_r    <= hd_nxt;
    hm_r    <= hm_nxt;
    fr_r    <= fr_nxt;
    cnt_r   <= cnt_nxt;
    idx_r   <= idx_nxt;
    total_r <= total_nxt;
    bad_r   <= bad_nxt;
    if (res_load) begin
      out_r <= res_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = {out_r.flow, out_r.total, out_r.msg, out_r.dest,
                       out_r.seg_length, out_r.slot};
  assign out_tlast  = out_r.last;

`ifndef SYNTH
  // The ring never holds more frames than it has slots.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCW'(frq_pkg::QDEPTH))
    else $error("occupancy above ring depth");

  // The emit pass never runs past the last frame of the run.
  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (cnt_r <= fr_r))
    else $error("segment index beyond run length");

  // A header write always commits exactly one frame.
  a_commit: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |=> (occ_r == $past(occ_r) + OCW'(1)))
    else $error("header write without occupancy step");

  // A result is only loaded when the output register can take it.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (!out_valid_r || out_tready))
    else $error("result register overwritten");
`endif

endmodule

### hdl/frq_hdr_mem.sv
// Header ring storage: one write port and one registered read port.
module frq_hdr_mem (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [frq_pkg::AW-1:0]   wr_addr,
  input  frq_pkg::hdr_t            wr_data,
  input  logic                     rd_en,
  input  logic [frq_pkg::AW-1:0]   rd_addr,
  output frq_pkg::hdr_t            rd_data
);

  frq_pkg::hdr_t mem [frq_pkg::QDEPTH];
  frq_pkg::hdr_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
